// File: src/vru_pkg.sv
// Shared constants and types for the vertex rank update block.
// Used by vru_div, vru_store and vertex_rank_update_top; no dependencies.
package vru_pkg;

  // Field widths of the transaction payload.
  localparam int VTX_W  = 10;
  localparam int RANK_W = 24;
  localparam int DEG_W  = 16;
  localparam int DAMP_W = 17;

  // Default number of vertices held in the stores.
  localparam int NODES_DEFAULT = 1024;

  // Fixed-point constants.
  localparam logic [RANK_W-1:0] RANK_MAX   = 24'hFF_FFFF;
  localparam logic [RANK_W-1:0] RANK_ONE   = 24'd65536;
  localparam logic [DEG_W-1:0]  DEG_MAX    = 16'hFFFF;
  localparam logic [DAMP_W-1:0] ONE_Q16    = 17'd65536;
  localparam logic [DAMP_W-1:0] DAMP_RESET = 17'd55706;

  // Radix-2 divider: one quotient bit per step.
  localparam int DIV_STEPS = RANK_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Operation codes.
  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_ACCUM = 1'b1;

  // Write enables from the sequencer to the vertex stores.
  typedef struct packed {
    logic rank_we;
    logic deg_we;
  } store_we_t;

endpackage

// File: src/vru_div.sv
// Iterative restoring divider: 24-bit rank over 16-bit out-degree, one bit per cycle.
// Depends on vru_pkg for widths and the step count.
module vru_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [vru_pkg::RANK_W-1:0]  dividend,
  input  logic [vru_pkg::DEG_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [vru_pkg::RANK_W-1:0]  quotient
);
  import vru_pkg::*;

  logic [DEG_W-1:0]     rem;
  logic [DEG_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEG_W:0]       trial;
  logic                 ge;
  logic [DEG_W-1:0]     rem_next;

  // One compare-subtract step on the shifted partial remainder.
  always_comb begin
    trial = {rem, quotient[RANK_W-1]};
    ge    = trial >= {1'b0, dvs};
    if (ge) begin
      rem_next = DEG_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[DEG_W-1:0];
    end
  end

  // Control: busy from start until the step count reaches zero, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: the quotient register shifts the dividend out and quotient bits in.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
      cnt      <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy) begin
      quotient <= {quotient[RANK_W-2:0], ge};
      rem      <= rem_next;
      cnt      <= cnt - 1'b1;
    end
  end

endmodule

// File: src/vru_store.sv
// Per-vertex rank and out-degree memories with a clearing pass after reset.
// Depends on vru_pkg for widths, reset values and the write-enable struct.
module vru_store #(
  parameter int NODES = vru_pkg::NODES_DEFAULT,
  parameter int AW    = (NODES > 1) ? $clog2(NODES) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  output logic                       clearing,
  input  logic [AW-1:0]              rd_addr,
  output logic [vru_pkg::RANK_W-1:0] rd_rank,
  output logic [vru_pkg::DEG_W-1:0]  rd_deg,
  input  vru_pkg::store_we_t         we,
  input  logic [AW-1:0]              wr_addr,
  input  logic [vru_pkg::RANK_W-1:0] rank_wdata,
  input  logic [vru_pkg::DEG_W-1:0]  deg_wdata
);
  import vru_pkg::*;

  logic [RANK_W-1:0] rank_mem [NODES];
  logic [DEG_W-1:0]  deg_mem  [NODES];
  logic [AW-1:0]     clear_idx;

  // Clearing pass: one entry per cycle from address zero to NODES-1.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_idx <= '0;
    end else if (clearing) begin
      clear_idx <= clear_idx + 1'b1;
      if (clear_idx == AW'(NODES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Rank memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (clearing) begin
      rank_mem[clear_idx] <= RANK_ONE;
    end else if (we.rank_we) begin
      rank_mem[wr_addr] <= rank_wdata;
    end
    rd_rank <= rank_mem[rd_addr];
  end

  // Out-degree memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (clearing) begin
      deg_mem[clear_idx] <= '0;
    end else if (we.deg_we) begin
      deg_mem[wr_addr] <= deg_wdata;
    end
    rd_deg <= deg_mem[rd_addr];
  end

endmodule

// File: src/vertex_rank_update_top.sv
// Vertex rank update top level: sequencer, running sum, damping multiply, result register.
// Depends on vru_pkg, vru_store and vru_div.
// Sequencing: an edge transaction passes through the lookup state only; an accumulate
// transaction with a contributing neighbor then runs the 24-step divider on the registered
// store read; a last transaction adds the multiply and finish states, and its result strobes
// on done in the cycle after the finish state. A new transaction is taken only in idle.
// Reset is synchronous; after reset the stores are swept over all NODES entries while busy
// is high. Results are shown for one cycle; the receiver cannot stall.
module vertex_rank_update_top #(
  parameter int NODES = vru_pkg::NODES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation,
  input  logic [vru_pkg::VTX_W-1:0]  target_vertex,
  input  logic [vru_pkg::VTX_W-1:0]  neighbor_vertex,
  input  logic                       has_neighbor,
  input  logic                       last,
  output logic                       done,
  output logic [vru_pkg::VTX_W-1:0]  updated_vertex,
  output logic [vru_pkg::RANK_W-1:0] new_rank,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [vru_pkg::DAMP_W-1:0] cfg_data
);
  import vru_pkg::*;

  localparam int AW     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int AW_EXT = (AW > VTX_W) ? AW : VTX_W;
  localparam int PROD_W = DAMP_W + RANK_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOKUP = 5'b00010,
    S_DIV    = 5'b00100,
    S_MUL    = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t state, state_next;

  logic              accept;
  logic              clearing;
  logic [DAMP_W-1:0] damping;
  logic              op_r;
  logic [VTX_W-1:0]  tgt_r;
  logic              tgt_ok;
  logic              nb_use;
  logic              last_r;
  logic [RANK_W-1:0] partial_sum;
  logic [PROD_W-1:0] prod;

  logic [AW_EXT-1:0] tgt_ext;
  logic [AW_EXT-1:0] rd_ext;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [RANK_W-1:0] rd_rank;
  logic [DEG_W-1:0]  rd_deg;
  store_we_t         we;
  logic [RANK_W-1:0] rank_wdata;
  logic [DEG_W-1:0]  deg_wdata;

  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [RANK_W-1:0] quotient;

  logic [RANK_W:0]   sum_wide;
  logic [RANK_W-1:0] sum_sat;
  logic [DAMP_W-1:0] d_clamp;
  logic [DAMP_W-1:0] base;
  logic [RANK_W+1:0] rank_wide;
  logic [RANK_W-1:0] rank_sat;

  assign accept    = start && !busy;
  assign busy      = clearing || (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Damping register, written through the configuration channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      damping <= DAMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      damping <= cfg_data;
    end
  end

  // Store addressing: read at the accepted vertex, write at the latched target.
  always_comb begin
    if (operation == OP_ACCUM) begin
      rd_ext = AW_EXT'(neighbor_vertex);
    end else begin
      rd_ext = AW_EXT'(target_vertex);
    end
    rd_addr = rd_ext[AW-1:0];
    tgt_ext = AW_EXT'(tgt_r);
    wr_addr = tgt_ext[AW-1:0];
  end

  // Latch the accepted transaction and its range checks.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= operation;
      tgt_r  <= target_vertex;
      tgt_ok <= 32'(target_vertex) < NODES;
      nb_use <= has_neighbor && (32'(neighbor_vertex) < NODES);
      last_r <= last;
    end
  end

  // Saturating sum update and final rank arithmetic.
  always_comb begin
    sum_wide = {1'b0, partial_sum} + {1'b0, quotient};
    sum_sat  = sum_wide[RANK_W] ? RANK_MAX : sum_wide[RANK_W-1:0];
    d_clamp  = (damping > ONE_Q16) ? ONE_Q16 : damping;
    base     = ONE_Q16 - d_clamp;
    rank_wide = (RANK_W+2)'(base) + (RANK_W+2)'(prod[PROD_W-1:16]);
    rank_sat  = (rank_wide > (RANK_W+2)'(RANK_MAX)) ? RANK_MAX : rank_wide[RANK_W-1:0];
  end

  // Sequencer next state and store / divider controls.
  always_comb begin
    state_next = state;
    we         = '0;
    div_start  = 1'b0;
    deg_wdata  = rd_deg + 1'b1;
    rank_wdata = rank_sat;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (op_r == OP_EDGE) begin
          we.deg_we  = tgt_ok && (rd_deg != DEG_MAX);
          state_next = S_IDLE;
        end else if (nb_use && rd_deg != '0) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else if (last_r) begin
          state_next = S_MUL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = last_r ? S_MUL : S_IDLE;
        end
      end
      S_MUL: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        we.rank_we = tgt_ok;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer state, running sum and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      partial_sum <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_DIV && div_done) begin
        partial_sum <= sum_sat;
      end
      if (state == S_FIN) begin
        partial_sum <= '0;
        done        <= 1'b1;
      end
    end
  end

  // Damping product and result payload registers.
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= d_clamp * partial_sum;
    end
    if (state == S_FIN) begin
      updated_vertex <= tgt_r;
      new_rank       <= rank_sat;
    end
  end

  vru_store #(
    .NODES(NODES),
    .AW   (AW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .rd_addr   (rd_addr),
    .rd_rank   (rd_rank),
    .rd_deg    (rd_deg),
    .we        (we),
    .wr_addr   (wr_addr),
    .rank_wdata(rank_wdata),
    .deg_wdata (deg_wdata)
  );

  vru_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(rd_rank),
    .divisor (rd_deg),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(quotient)
  );

`ifndef SYNTHESIS
  // A result strobe follows only the finishing state.
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FIN))
    else $error("result strobe without a finishing step");

  // The divider is never restarted while it is still iterating.
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // The divider runs only while the sequencer waits on it.
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == S_DIV))
    else $error("divider running outside the divide step");

  // No store write reaches the memories while the clearing pass runs.
  a_no_write_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (we == '0))
    else $error("store write during clearing pass");
`endif

endmodule
